>>> src/rmsd_pkg.sv
// Shared types and constants for the marker run-length stream decoder.
// Used by rmsd_front, rmsd_back and rle_marker_stream_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rmsd_pkg;

   localparam int IN_DEPTH_DEFAULT  = 4;
   localparam int OUT_DEPTH_DEFAULT = 2;

   localparam logic [7:0] LONG_FLAG = 8'h80;
   localparam logic [6:0] HIGH_MASK = 7'h7f;
   localparam logic [7:0] SHORT_MAX = 8'd2;

   // One stream byte with its frame flags and the count decode done up front.
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
      logic       cnt_short;
      logic       cnt_long;
   } word_type;

   typedef struct packed {
      logic     valid;
      word_type word;
   } feed_type;

   typedef struct packed {
      logic [7:0]  symbol;
      logic [15:0] run_length;
      logic        stream_end;
      logic        status;
   } result_type;

   typedef enum logic [5:0] {
      PH_TAG     = 6'b000001,
      PH_MARKER  = 6'b000010,
      PH_DATA    = 6'b000100,
      PH_COUNT   = 6'b001000,
      PH_COUNTLO = 6'b010000,
      PH_SYMBOL  = 6'b100000
   } phase_type;

endpackage

`default_nettype wire

>>> src/rmsd_queue.sv
// Small first-in first-out queue of WIDTH-bit words held in flip-flops.
// Self-contained; instantiated by rmsd_front and rmsd_back.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count exceeds depth");

   a_push_full_holds: assert property (@(posedge clock) disable iff (reset)
      (full && !pop) |=> (count_ff == $past(count_ff)))
      else $error("queue count moved while full with no pop");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue pop did not reduce the count");

endmodule

`default_nettype wire

>>> src/rmsd_front.sv
// Front end: takes stream words, decodes the count byte forms and queues them.
// Depends on rmsd_pkg and rmsd_queue.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_front #(
   parameter int DEPTH = rmsd_pkg::IN_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        in_byte,
   input  wire logic              frame_start,
   input  wire logic              frame_last,
   input  wire logic              push,
   output logic                   full,
   output rmsd_pkg::feed_type     feed,
   input  wire logic              feed_pop
);

   import rmsd_pkg::*;

   word_type wr_word, rd_word;
   logic     q_empty;

   always_comb begin
      wr_word.data      = in_byte;
      wr_word.start     = frame_start;
      wr_word.last      = frame_last;
      wr_word.cnt_short = (in_byte <= SHORT_MAX);
      wr_word.cnt_long  = ((in_byte & LONG_FLAG) != 8'h00);
   end

   rmsd_queue #(
      .WIDTH ($bits(word_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_word),
      .full    (full),
      .pop     (feed_pop),
      .rd_data (rd_word),
      .empty   (q_empty)
   );

   assign feed.valid = !q_empty;
   assign feed.word  = rd_word;

endmodule

`default_nettype wire

>>> src/rmsd_back.sv
// Back end: marker run-length parser and the result queue.
// Depends on rmsd_pkg and rmsd_queue.
`timescale 1ns / 1ps
`default_nettype none

module rmsd_back #(
   parameter int DEPTH = rmsd_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rmsd_pkg::feed_type feed,
   output logic                    feed_pop,
   output rmsd_pkg::result_type    result,
   output logic                    empty,
   input  wire logic               pop
);

   import rmsd_pkg::*;

   phase_type   phase_ff, phase_in, ph, next;
   logic [7:0]  marker_ff, marker_in;
   logic [14:0] pending_ff, pending_in;
   logic        have, take, out_full, res_push;
   logic [7:0]  sym;
   logic [15:0] len;
   result_type  res;
   word_type    w;

   assign w    = feed.word;
   assign take = feed.valid && !out_full;
   assign feed_pop = take;

   always_comb begin
      ph         = w.start ? PH_TAG : phase_ff;
      next       = ph;
      have       = 1'b0;
      sym        = 8'h00;
      len        = 16'h0000;
      marker_in  = marker_ff;
      pending_in = pending_ff;
      unique case (ph)
         PH_MARKER: begin
            marker_in = w.data;
            next      = PH_DATA;
         end
         PH_DATA: begin
            if (w.data == marker_ff) begin
               next = PH_COUNT;
            end else begin
               have = 1'b1;
               sym  = w.data;
               len  = 16'd1;
            end
         end
         PH_COUNT: begin
            if (w.cnt_short) begin
               have = 1'b1;
               sym  = marker_ff;
               len  = {8'h00, w.data} + 16'd1;
               next = PH_DATA;
            end else if (w.cnt_long) begin
               pending_in = {w.data[6:0] & HIGH_MASK, 8'h00};
               next       = PH_COUNTLO;
            end else begin
               pending_in = {7'h00, w.data};
               next       = PH_SYMBOL;
            end
         end
         PH_COUNTLO: begin
            pending_in = {pending_ff[14:8], w.data};
            next       = PH_SYMBOL;
         end
         PH_SYMBOL: begin
            have = 1'b1;
            sym  = w.data;
            len  = {1'b0, pending_ff} + 16'd1;
            next = PH_DATA;
         end
         default: begin
            // The tag byte is skipped; the marker definition follows.
            next = PH_MARKER;
         end
      endcase
      phase_in = w.last ? PH_TAG : next;
   end

   // A last word always yields a result; without a finished token it is
   // status-only, flagged as truncated unless the parser sits between tokens.
   always_comb begin
      res_push = take && (have || w.last);
      if (have) begin
         res.symbol     = sym;
         res.run_length = len;
         res.stream_end = w.last;
         res.status     = 1'b0;
      end else begin
         res.symbol     = 8'h00;
         res.run_length = 16'h0000;
         res.stream_end = 1'b1;
         res.status     = (next != PH_DATA);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TAG;
         marker_ff  <= 8'h00;
         pending_ff <= 15'h0000;
      end else if (take) begin
         phase_ff   <= phase_in;
         marker_ff  <= marker_in;
         pending_ff <= pending_in;
      end
   end

   rmsd_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res),
      .full    (out_full),
      .pop     (pop),
      .rd_data (result),
      .empty   (empty)
   );

   a_last_resets_phase: assert property (@(posedge clock) disable iff (reset)
      (take && w.last) |=> (phase_ff == PH_TAG))
      else $error("parser did not return to the tag phase after a last word");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (take && w.last) |-> (res_push && res.stream_end))
      else $error("last word produced no end-of-stream result");

   a_truncated_no_data: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.status) |-> (res.run_length == 16'h0000 && res.stream_end))
      else $error("truncation status on a result that carries data");

   a_no_pop_when_stuck: assert property (@(posedge clock) disable iff (reset)
      (feed.valid && out_full) |=> (phase_ff == $past(phase_ff)))
      else $error("parser advanced while the result queue was full");

endmodule

`default_nettype wire

>>> src/rle_marker_stream_decoder.sv
// Marker run-length stream decoder: one compressed word in, at most one
// (symbol, run length) result out. Depends on rmsd_pkg, rmsd_front, rmsd_back.
//
// Usage:
//   Input side is a queue write port: present req_in_byte, req_frame_start and
//   req_frame_last with push; the word is taken on a clock edge where push is
//   high and full is low. Result side is a queue read port: while empty is low
//   the oldest result is on rsp_symbol, rsp_run_length, rsp_stream_end and
//   rsp_status, and pop takes it.
//   A word that finishes a token is held in the input queue, then the parser
//   writes its result into the result queue, where pop can take it.
//   Throughput: one word per cycle while the result queue is not full, bounded
//   by the single parser phase register, which advances once per word.
//   A stalled receiver fills the result queue (OutDepth words); the parser
//   then holds, the input queue fills (InDepth words) and full rises. No word
//   or result is dropped.
//   Reset (synchronous, active high) empties both queues and puts the parser
//   in the tag phase with marker and count cleared.
`timescale 1ns / 1ps
`default_nettype none

module rle_marker_stream_decoder #(
   parameter int InDepth  = rmsd_pkg::IN_DEPTH_DEFAULT,
   parameter int OutDepth = rmsd_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_frame_start,
   input  wire logic        req_frame_last,
   input  wire logic        push,
   output logic             full,
   output logic [7:0]       rsp_symbol,
   output logic [15:0]      rsp_run_length,
   output logic             rsp_stream_end,
   output logic             rsp_status,
   output logic             empty,
   input  wire logic        pop
);

   import rmsd_pkg::*;

   feed_type   feed;
   logic       feed_pop;
   result_type result;

   rmsd_front #(
      .DEPTH (InDepth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_in_byte),
      .frame_start (req_frame_start),
      .frame_last  (req_frame_last),
      .push        (push),
      .full        (full),
      .feed        (feed),
      .feed_pop    (feed_pop)
   );

   rmsd_back #(
      .DEPTH (OutDepth)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .feed     (feed),
      .feed_pop (feed_pop),
      .result   (result),
      .empty    (empty),
      .pop      (pop)
   );

   assign rsp_symbol     = result.symbol;
   assign rsp_run_length = result.run_length;
   assign rsp_stream_end = result.stream_end;
   assign rsp_status     = result.status;

endmodule

`default_nettype wire

>>> tb/rle_token_checker.sv
// Checker for the marker run-length stream decoder: watches both queue ports,
// predicts each (symbol, run length) result and compares what the block pops.
// Depends on rmsd_pkg for the result layout, the phase encoding and the count constants.
`timescale 1ns / 1ps

module rle_token_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_start,
   input  logic        req_frame_last,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  rsp_symbol,
   input  logic [15:0] rsp_run_length,
   input  logic        rsp_stream_end,
   input  logic        rsp_status,
   input  logic        empty,
   input  logic        pop,
   output int          mismatches,
   output int          runs_outstanding,
   output int          words_taken,
   output int          runs_checked,
   output int          truncations,
   output int          long_runs
);
   import rmsd_pkg::*;

   result_type   pending_runs[$];
   phase_type    parse_phase = PH_TAG;
   logic [7:0]   marker_byte = 8'h00;
   logic [14:0]  count_hold = 15'h0000;
   int           fails = 0;
   int           words = 0;
   int           checked = 0;
   int           flagged = 0;
   int           longs = 0;

   // Advances the parser copy by one word and queues the result it causes.
   task automatic decode_word(input logic [7:0] b, input logic first, input logic closing);
      phase_type  ph;
      phase_type  nxt;
      logic       produced;
      result_type run;
      ph = first ? PH_TAG : parse_phase;
      nxt = ph;
      produced = 1'b0;
      run = '0;
      case (ph)
         PH_MARKER: begin
            marker_byte = b;
            nxt = PH_DATA;
         end
         PH_DATA: begin
            if (b == marker_byte) begin
               nxt = PH_COUNT;
            end else begin
               produced = 1'b1;
               run.symbol = b;
               run.run_length = 16'd1;
            end
         end
         PH_COUNT: begin
            if (b <= SHORT_MAX) begin
               produced = 1'b1;
               run.symbol = marker_byte;
               run.run_length = 16'(b) + 16'd1;
               nxt = PH_DATA;
            end else if ((b & LONG_FLAG) != 8'h00) begin
               count_hold = {b[6:0] & HIGH_MASK, 8'h00};
               nxt = PH_COUNTLO;
            end else begin
               count_hold = 15'(b);
               nxt = PH_SYMBOL;
            end
         end
         PH_COUNTLO: begin
            count_hold = {count_hold[14:8], b};
            nxt = PH_SYMBOL;
         end
         PH_SYMBOL: begin
            produced = 1'b1;
            run.symbol = b;
            run.run_length = {1'b0, count_hold} + 16'd1;
            nxt = PH_DATA;
         end
         default: begin
            nxt = PH_MARKER;
         end
      endcase

      if (closing) begin
         parse_phase = PH_TAG;
         if (!produced) begin
            // A stream that stops right after its marker definition is empty but whole.
            run = '0;
            run.status = (nxt != PH_DATA);
         end
         run.stream_end = 1'b1;
         pending_runs.push_back(run);
      end else begin
         parse_phase = nxt;
         if (produced) pending_runs.push_back(run);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         pending_runs.delete();
         parse_phase = PH_TAG;
         marker_byte = 8'h00;
         count_hold = 15'h0000;
      end else begin
         // Results always trail the word that causes them, so compare first.
         if (pop && !empty) begin
            if (pending_runs.size() == 0) begin
               $error("result word popped with nothing expected: symbol %0h run %0h",
                      rsp_symbol, rsp_run_length);
               fails++;
            end else begin
               want = pending_runs.pop_front();
               check_field("symbol", 16'(want.symbol), 16'(rsp_symbol));
               check_field("run_length", want.run_length, rsp_run_length);
               check_field("stream_end", 16'(want.stream_end), 16'(rsp_stream_end));
               check_field("status", 16'(want.status), 16'(rsp_status));
               checked++;
               if (want.status) flagged++;
               if (want.run_length > 16'd127) longs++;
            end
         end
         if (push && !full) begin
            decode_word(req_in_byte, req_frame_start, req_frame_last);
            words++;
         end
      end
      mismatches <= fails;
      runs_outstanding <= pending_runs.size();
      words_taken <= words;
      runs_checked <= checked;
      truncations <= flagged;
      long_runs <= longs;
   end

endmodule

>>> tb/testbench.sv
// Top of the marker run-length stream decoder bench: clock, reset, byte-stream
// stimulus and result-side stalls. Depends on rle_marker_stream_decoder and rle_token_checker.
`timescale 1ns / 1ps

module testbench;

   localparam int DIRECTED_WORDS = 24;
   localparam int RANDOM_WORDS   = 950;
   localparam int IDLE_LIMIT     = 2000;

   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_type;

   logic        clock;
   logic        reset = 1'b1;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        req_frame_last = 1'b0;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  rsp_symbol;
   logic [15:0] rsp_run_length;
   logic        rsp_stream_end;
   logic        rsp_status;
   logic        empty;
   logic        pop = 1'b0;

   int          mismatches;
   int          runs_outstanding;
   int          words_taken;
   int          runs_checked;
   int          truncations;
   int          long_runs;

   logic [7:0]  stream_bytes[$];
   int          words_sent = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   logic [8:0]  rx_tick = '0;
   rx_mode_type rx_mode;

   rle_marker_stream_decoder uut (
      .clock(clock),
      .reset(reset),
      .req_in_byte(req_in_byte),
      .req_frame_start(req_frame_start),
      .req_frame_last(req_frame_last),
      .push(push),
      .full(full),
      .rsp_symbol(rsp_symbol),
      .rsp_run_length(rsp_run_length),
      .rsp_stream_end(rsp_stream_end),
      .rsp_status(rsp_status),
      .empty(empty),
      .pop(pop)
   );

   rle_token_checker token_check (
      .clock(clock),
      .reset(reset),
      .req_in_byte(req_in_byte),
      .req_frame_start(req_frame_start),
      .req_frame_last(req_frame_last),
      .push(push),
      .full(full),
      .rsp_symbol(rsp_symbol),
      .rsp_run_length(rsp_run_length),
      .rsp_stream_end(rsp_stream_end),
      .rsp_status(rsp_status),
      .empty(empty),
      .pop(pop),
      .mismatches(mismatches),
      .runs_outstanding(runs_outstanding),
      .words_taken(words_taken),
      .runs_checked(runs_checked),
      .truncations(truncations),
      .long_runs(long_runs)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver cycles through free-running, coin-flip, sparse and mostly blocked windows.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rx_tick <= '0;
      end else begin
         rx_tick <= rx_tick + 9'd1;
         rx_mode = rx_mode_type'(rx_tick[8:7]);
         case (rx_mode)
            RX_FREE:   pop <= 1'b1;
            RX_COIN:   pop <= ($urandom_range(0, 1) == 0);
            RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:   pop <= (rx_tick[4:0] > 5'd21);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles with no word moving.", IDLE_LIMIT);
            $display("rle_marker_stream_decoder verification failed");
            $finish;
         end
      end
   end

   // Offers one word and returns on the edge that takes it; idles between bursts.
   task automatic send_word(input logic [7:0] b, input logic first, input logic closing);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_in_byte <= b;
      req_frame_start <= first;
      req_frame_last <= closing;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic flush_stream(input logic first, input logic closing);
      foreach (stream_bytes[i]) begin
         send_word(stream_bytes[i], (i == 0) ? first : 1'b0,
                   closing && (i == stream_bytes.size() - 1));
      end
      stream_bytes.delete();
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (runs_outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_marker();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Builds a tag, a marker and well-formed tokens, sometimes cut off mid-token.
   task automatic build_stream(input int tokens);
      logic [7:0] mark;
      logic [7:0] b;
      int         kind;
      mark = pick_marker();
      stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(mark);
      repeat (tokens) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            b = 8'($urandom_range(0, 255));
            if (b == mark) b = ~mark;
            stream_bytes.push_back(b);
         end else if (kind < 65) begin
            stream_bytes.push_back(mark);
            stream_bytes.push_back(8'($urandom_range(0, 2)));
         end else if (kind < 85) begin
            stream_bytes.push_back(mark);
            stream_bytes.push_back(8'($urandom_range(3, 127)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            stream_bytes.push_back(mark);
            case ($urandom_range(0, 3))
               0:       stream_bytes.push_back(8'h80);
               1:       stream_bytes.push_back(8'hFF);
               default: stream_bytes.push_back(8'($urandom_range(128, 255)));
            endcase
            stream_bytes.push_back(8'($urandom_range(0, 255)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      case ($urandom_range(0, 9))
         0: stream_bytes.push_back(mark);
         1: begin
            stream_bytes.push_back(mark);
            stream_bytes.push_back(8'($urandom_range(3, 127)));
         end
         2: begin
            stream_bytes.push_back(mark);
            stream_bytes.push_back(8'($urandom_range(128, 255)));
         end
         3: begin
            stream_bytes.push_back(mark);
            stream_bytes.push_back(8'($urandom_range(128, 255)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endtask

   initial begin
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A stream that is nothing but its tag is flagged as truncated.
      send_word(8'h5A, 1'b1, 1'b1);
      // Plain byte, marker repeats at both short-count edges, short and long counts,
      // a long-form count of zero and the largest run, closed by the last token.
      stream_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h02,
                       8'hFF, 8'h03, 8'h41, 8'hFF, 8'h7F, 8'h00,
                       8'hFF, 8'h80, 8'h00, 8'h11, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
      flush_stream(1'b1, 1'b1);
      // Tag and marker only: an empty stream that still ends cleanly.
      stream_bytes = '{8'hA5, 8'h3C};
      flush_stream(1'b1, 1'b1);
      wait_drained();

      while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_stream(($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 20));
            flush_stream($urandom_range(0, 7) != 0, 1'b1);
         end else if (pick < 82) begin
            // Left open, so the next frame start drops whatever token is unfinished.
            build_stream($urandom_range(1, 10));
            flush_stream(1'b1, 1'b0);
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) begin
               send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                         $urandom_range(0, 7) == 0);
            end
         end else if (pick < 96) begin
            if ($urandom_range(0, 1) == 0) begin
               send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            end else begin
               build_stream(0);
               flush_stream(1'b1, 1'b1);
            end
         end else begin
            wait_drained();
         end
      end

      push <= 1'b0;
      @(posedge clock);
      while (runs_outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Fed %0d stream words and checked %0d decoded runs.", words_taken,
               runs_checked);
      $display("Among them %0d truncated-stream flags and %0d runs longer than 127.",
               truncations, long_runs);
      if (mismatches == 0) begin
         $display("rle_marker_stream_decoder verification clean");
      end else begin
         $display("rle_marker_stream_decoder verification failed");
      end
      $finish;
   end

endmodule
